[rtl/msbm_pkg.sv]
// ----------------------------------------------------------------------------
// msbm_pkg: shared types and constants for the multi-stack block mover
// Sizes of the stack store, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package msbm_pkg;

    localparam int NUM_STACKS  = 16;
    localparam int STACK_DEPTH = 128;

    localparam int STK_W   = $clog2(NUM_STACKS);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NUM_STACKS * STACK_DEPTH);
    localparam int SUM_W   = ((DEPTH_W > 8) ? DEPTH_W : 8) + 1;

    typedef logic [STK_W-1:0]   stk_idx_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SUM_W-1:0]   sum_t;

    // operation codes
    localparam logic [1:0] FN_PUSH = 2'd0;
    localparam logic [1:0] FN_MOVE = 2'd1;
    localparam logic [1:0] FN_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [7:0] EMPTY_MARK = 8'd32;

    // access to the depth table
    typedef struct packed {
        logic     we;
        stk_idx_t waddr;
        depth_t   wdata;
        stk_idx_t raddr;
    } dtbl_req_t;

endpackage

[rtl/msbm_ram.sv]
// ----------------------------------------------------------------------------
// msbm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module msbm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/msbm_depth_tbl.sv]
// ----------------------------------------------------------------------------
// msbm_depth_tbl: per-stack depth counts
// RAM of depth counts with one valid flag per stack; a stack never written
// since reset reads as empty.
// ----------------------------------------------------------------------------
module msbm_depth_tbl (
    input  logic                aclk,
    input  logic                aresetn,
    input  msbm_pkg::dtbl_req_t req,
    output msbm_pkg::depth_t    rdata
);

    logic                     vld_reg [msbm_pkg::NUM_STACKS];
    logic                     vld_rd_reg;
    msbm_pkg::depth_t         ram_q;

    msbm_ram #(
        .DATA_W (msbm_pkg::DEPTH_W),
        .DEPTH  (msbm_pkg::NUM_STACKS)
    ) u_ram (
        .aclk   (aclk),
        .we     (req.we),
        .waddr  (req.waddr),
        .wdata  (req.wdata),
        .raddr  (req.raddr),
        .rdata  (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msbm_pkg::NUM_STACKS; i++) begin
                vld_reg[i] <= 1'b0;
            end
            vld_rd_reg <= 1'b0;
        end else begin
            if (req.we) begin
                vld_reg[req.waddr] <= 1'b1;
            end
            vld_rd_reg <= vld_reg[req.raddr];
        end
    end

    assign rdata = vld_rd_reg ? ram_q : '0;

endmodule

[rtl/multi_stack_block_move.sv]
// ----------------------------------------------------------------------------
// multi_stack_block_move: byte stacks in one store with ordered block move
// Input stream carries one operation per transaction (push, move, peek);
// every operation returns exactly one result transaction.
//
// s_tdata : func[1:0], src_stack[5:2], dst_stack[9:6], move_count[17:10],
//           push_value[25:18]. m_tdata: top_value[7:0], stack_depth[15:8],
//           status[17:16].
// One operation is worked at a time. s_tready is high while the sequencer
// is idle; a result not yet taken holds the sequencer in S_OUT.
// Each operation reads the source, then the destination depth and is
// evaluated; a taken push writes its byte, a move of N > 0 items copies
// its block then writes both depths, and other operations with a used code
// read the top item unless the stack is empty. A move copies one byte per
// cycle through the item RAM (each byte is read, then written while the
// next is read), so the item RAM port sets the move time.
// Depth counts live in a small RAM read one stack per cycle.
// Reset empties every stack at once (per-stack valid flags); no clearing
// pass. While m_tready is low the finished result holds in the output
// register and the block stalls before delivering the next one.
// ----------------------------------------------------------------------------
module multi_stack_block_move (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // func, src_stack, dst_stack, move_count, push_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // top_value, stack_depth, status
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DSRC  = 10'b00_0000_0010,
        S_DDST  = 10'b00_0000_0100,
        S_EVAL  = 10'b00_0000_1000,
        S_COPY  = 10'b00_0001_0000,
        S_DUPD  = 10'b00_0010_0000,
        S_DUPD2 = 10'b00_0100_0000,
        S_TRD   = 10'b00_1000_0000,
        S_TWT   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]          op_reg;
    logic [3:0]          src_reg;
    logic [3:0]          dst_reg;
    logic [7:0]          cnt_reg;
    logic [7:0]          val_reg;
    msbm_pkg::addr_t     src_base_reg, dst_base_reg;
    msbm_pkg::depth_t    ds_reg, dd_reg;
    msbm_pkg::addr_t     rd_addr_reg, rd_addr_next;
    msbm_pkg::addr_t     wr_addr_reg, wr_addr_next;
    logic [7:0]          rem_reg, rem_next;
    logic                pend_reg, pend_next;
    logic [7:0]          last_reg, last_next;
    msbm_pkg::addr_t     rep_base_reg, rep_base_next;
    msbm_pkg::depth_t    rep_depth_reg, rep_depth_next;
    logic [1:0]          status_reg, status_next;
    logic [7:0]          res_top_reg, res_top_next;

    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;

    // item RAM ports
    logic                item_we;
    msbm_pkg::addr_t     item_waddr;
    logic [7:0]          item_wdata;
    msbm_pkg::addr_t     item_raddr;
    logic [7:0]          item_rdata;

    msbm_pkg::dtbl_req_t dtbl_req;
    msbm_pkg::depth_t    dtbl_rdata;

    logic                s_fire;
    logic                out_load;
    logic                src_bad, dst_bad, req_bad;
    msbm_pkg::sum_t      ds_w, dd_w, cnt_w;
    logic                mv_under, mv_over, push_over;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    msbm_ram #(
        .DATA_W (8),
        .DEPTH  (msbm_pkg::NUM_STACKS * msbm_pkg::STACK_DEPTH)
    ) u_item_ram (
        .aclk   (aclk),
        .we     (item_we),
        .waddr  (item_waddr),
        .wdata  (item_wdata),
        .raddr  (item_raddr),
        .rdata  (item_rdata)
    );

    msbm_depth_tbl u_depth_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dtbl_req),
        .rdata   (dtbl_rdata)
    );

    // request checks
    assign src_bad = 32'(src_reg) >= msbm_pkg::NUM_STACKS;
    assign dst_bad = 32'(dst_reg) >= msbm_pkg::NUM_STACKS;

    always_comb begin
        unique case (op_reg)
            msbm_pkg::FN_PUSH: req_bad = dst_bad;
            msbm_pkg::FN_MOVE: req_bad = src_bad || dst_bad;
            msbm_pkg::FN_PEEK: req_bad = src_bad;
            default:           req_bad = 1'b1;
        endcase
    end

    assign ds_w      = msbm_pkg::sum_t'(ds_reg);
    assign dd_w      = msbm_pkg::sum_t'(dd_reg);
    assign cnt_w     = msbm_pkg::sum_t'(cnt_reg);
    assign mv_under  = cnt_w > ds_w;
    assign mv_over   = (dd_w + cnt_w) > msbm_pkg::sum_t'(msbm_pkg::STACK_DEPTH);
    assign push_over = dd_w >= msbm_pkg::sum_t'(msbm_pkg::STACK_DEPTH);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        rem_next       = rem_reg;
        pend_next      = 1'b0;
        last_next      = last_reg;
        rep_base_next  = rep_base_reg;
        rep_depth_next = rep_depth_reg;
        status_next    = status_reg;
        res_top_next   = res_top_reg;

        item_we        = 1'b0;
        item_waddr     = wr_addr_reg;
        item_wdata     = item_rdata;
        item_raddr     = rd_addr_reg;

        dtbl_req.we    = 1'b0;
        dtbl_req.waddr = msbm_pkg::stk_idx_t'(dst_reg);
        dtbl_req.wdata = msbm_pkg::depth_t'(dd_w + cnt_w);
        dtbl_req.raddr = msbm_pkg::stk_idx_t'(dst_reg);

        unique case (state_reg)
            S_IDLE: begin
                dtbl_req.raddr = msbm_pkg::stk_idx_t'(s_tdata[5:2]);
                if (s_fire) begin
                    state_next = S_DSRC;
                end
            end
            S_DSRC: begin
                state_next = S_DDST;
            end
            S_DDST: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (req_bad) begin
                    res_top_next   = msbm_pkg::EMPTY_MARK;
                    rep_depth_next = '0;
                    status_next    = msbm_pkg::ST_BAD;
                    state_next     = S_OUT;
                end else begin
                    unique case (op_reg)
                        msbm_pkg::FN_PUSH: begin
                            rep_base_next  = dst_base_reg;
                            rep_depth_next = dd_reg;
                            if (push_over) begin
                                status_next = msbm_pkg::ST_OVER;
                                state_next  = S_TRD;
                            end else begin
                                item_we        = 1'b1;
                                item_waddr     = msbm_pkg::addr_t'(dst_base_reg +
                                                 msbm_pkg::addr_t'(dd_reg));
                                item_wdata     = val_reg;
                                dtbl_req.we    = 1'b1;
                                dtbl_req.wdata = msbm_pkg::depth_t'(dd_w + 1'b1);
                                rep_depth_next = msbm_pkg::depth_t'(dd_w + 1'b1);
                                res_top_next   = val_reg;
                                status_next    = msbm_pkg::ST_OK;
                                state_next     = S_OUT;
                            end
                        end
                        msbm_pkg::FN_MOVE: begin
                            rep_base_next  = dst_base_reg;
                            rep_depth_next = dd_reg;
                            state_next     = S_TRD;
                            if (src_reg == dst_reg) begin
                                status_next = msbm_pkg::ST_BAD;
                            end else if (mv_under) begin
                                status_next = msbm_pkg::ST_UNDER;
                            end else if (mv_over) begin
                                status_next = msbm_pkg::ST_OVER;
                            end else begin
                                status_next = msbm_pkg::ST_OK;
                                if (cnt_reg != 8'd0) begin
                                    rd_addr_next = msbm_pkg::addr_t'(src_base_reg +
                                                   msbm_pkg::addr_t'(ds_reg) -
                                                   msbm_pkg::addr_t'(cnt_reg));
                                    wr_addr_next = msbm_pkg::addr_t'(dst_base_reg +
                                                   msbm_pkg::addr_t'(dd_reg));
                                    rem_next     = cnt_reg;
                                    state_next   = S_COPY;
                                end
                            end
                        end
                        default: begin
                            // peek
                            rep_base_next  = src_base_reg;
                            rep_depth_next = ds_reg;
                            status_next    = msbm_pkg::ST_OK;
                            state_next     = S_TRD;
                        end
                    endcase
                end
            end
            S_COPY: begin
                // read byte i while writing byte i-1
                if (rem_reg != 8'd0) begin
                    rd_addr_next = msbm_pkg::addr_t'(rd_addr_reg + 1'b1);
                    rem_next     = rem_reg - 8'd1;
                    pend_next    = 1'b1;
                end
                if (pend_reg) begin
                    item_we      = 1'b1;
                    wr_addr_next = msbm_pkg::addr_t'(wr_addr_reg + 1'b1);
                    last_next    = item_rdata;
                    if (rem_reg == 8'd0) begin
                        state_next = S_DUPD;
                    end
                end
            end
            S_DUPD: begin
                dtbl_req.we    = 1'b1;
                dtbl_req.waddr = msbm_pkg::stk_idx_t'(src_reg);
                dtbl_req.wdata = msbm_pkg::depth_t'(ds_w - cnt_w);
                state_next     = S_DUPD2;
            end
            S_DUPD2: begin
                dtbl_req.we    = 1'b1;
                rep_depth_next = msbm_pkg::depth_t'(dd_w + cnt_w);
                res_top_next   = last_reg;
                state_next     = S_OUT;
            end
            S_TRD: begin
                item_raddr = msbm_pkg::addr_t'(rep_base_reg +
                             msbm_pkg::addr_t'(rep_depth_reg) - 1'b1);
                if (rep_depth_reg == '0) begin
                    res_top_next = msbm_pkg::EMPTY_MARK;
                    state_next   = S_OUT;
                end else begin
                    state_next   = S_TWT;
                end
            end
            S_TWT: begin
                res_top_next = item_rdata;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // operation fields and working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg       <= s_tdata[1:0];
            src_reg      <= s_tdata[5:2];
            dst_reg      <= s_tdata[9:6];
            cnt_reg      <= s_tdata[17:10];
            val_reg      <= s_tdata[25:18];
            src_base_reg <= msbm_pkg::addr_t'(msbm_pkg::addr_t'(s_tdata[5:2]) *
                            msbm_pkg::addr_t'(msbm_pkg::STACK_DEPTH));
            dst_base_reg <= msbm_pkg::addr_t'(msbm_pkg::addr_t'(s_tdata[9:6]) *
                            msbm_pkg::addr_t'(msbm_pkg::STACK_DEPTH));
        end
        if (state_reg == S_DSRC) begin
            ds_reg <= dtbl_rdata;
        end
        if (state_reg == S_DDST) begin
            dd_reg <= dtbl_rdata;
        end
        rd_addr_reg   <= rd_addr_next;
        wr_addr_reg   <= wr_addr_next;
        rem_reg       <= rem_next;
        last_reg      <= last_next;
        rep_base_reg  <= rep_base_next;
        rep_depth_reg <= rep_depth_next;
        status_reg    <= status_next;
        res_top_reg   <= res_top_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'd0, status_reg, 8'(rep_depth_reg), res_top_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    a_item_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        item_we |-> (state_reg == S_EVAL || state_reg == S_COPY))
        else $error("item store written in unexpected state");

    a_copy_in_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_we && state_reg == S_COPY) |->
            (32'(wr_addr_reg) >= 32'(dst_base_reg) &&
             32'(wr_addr_reg) < 32'(dst_base_reg) + msbm_pkg::STACK_DEPTH))
        else $error("block copy wrote outside destination stack");

    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        dtbl_req.we |-> (32'(dtbl_req.wdata) <= msbm_pkg::STACK_DEPTH))
        else $error("stack depth written beyond capacity");
`endif

endmodule

[sim/multi_stack_block_move_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_block_move_tb: self-checking bench for the multi-stack mover
// Drives push, move, peek and unused-code operations through the input
// stream in bursts with random gaps. It predicts each result from a local
// copy of the stacks and checks every result transaction in order while
// the result side stalls on a rotating ready pattern.
// ----------------------------------------------------------------------------
module multi_stack_block_move_tb;
    import msbm_pkg::*;

    localparam int N_RANDOM    = 1225;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0] val;
        logic [7:0] cnt;
        logic [3:0] dst;
        logic [3:0] src;
        logic [1:0] func;
    } stack_op_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] depth;
        logic [7:0] top;
    } stack_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    multi_stack_block_move dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    stack_op_t  pending_ops[$];
    stack_res_t expected_results[$];
    int         plan_depth[NUM_STACKS];
    logic [7:0] byte_store[NUM_STACKS][STACK_DEPTH];
    int         depth_tbl[NUM_STACKS];
    int         n_total    = 0;
    int         n_accepted = 0;
    int         n_errors   = 0;
    int         cycles     = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic stack_res_t stack_view(int s, logic [1:0] st);
        stack_res_t r;
        r.status = st;
        r.depth  = depth_tbl[s][7:0];
        r.top    = (depth_tbl[s] > 0) ? byte_store[s][depth_tbl[s]-1] : EMPTY_MARK;
        return r;
    endfunction

    function automatic stack_res_t apply_stack_op(stack_op_t op);
        stack_res_t res;
        int s, d, c, ds, dd, i;
        s = op.src;
        d = op.dst;
        c = op.cnt;
        res.status = ST_BAD;
        res.depth  = 8'd0;
        res.top    = EMPTY_MARK;
        case (op.func)
            FN_PUSH: if (d < NUM_STACKS) begin
                if (depth_tbl[d] >= STACK_DEPTH) begin
                    res = stack_view(d, ST_OVER);
                end else begin
                    byte_store[d][depth_tbl[d]] = op.val;
                    depth_tbl[d]++;
                    res = stack_view(d, ST_OK);
                end
            end
            FN_MOVE: if (s < NUM_STACKS && d < NUM_STACKS) begin
                ds = depth_tbl[s];
                dd = depth_tbl[d];
                if (s == d) begin
                    res = stack_view(d, ST_BAD);
                end else if (c > ds) begin
                    res = stack_view(d, ST_UNDER);
                end else if (dd + c > STACK_DEPTH) begin
                    res = stack_view(d, ST_OVER);
                end else begin
                    // block keeps its order: lowest moved item lands first
                    for (i = 0; i < c; i++)
                        byte_store[d][dd+i] = byte_store[s][ds-c+i];
                    depth_tbl[s] = ds - c;
                    depth_tbl[d] = dd + c;
                    res = stack_view(d, ST_OK);
                end
            end
            FN_PEEK: if (s < NUM_STACKS) begin
                res = stack_view(s, ST_OK);
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus planning: track depths only, to shape legal sequences
    // ------------------------------------------------------------------
    task automatic queue_op(input logic [1:0] f, input int s, input int d,
                            input int c, input int v);
        stack_op_t o;
        o.func = f;
        o.src  = s[3:0];
        o.dst  = d[3:0];
        o.cnt  = c[7:0];
        o.val  = v[7:0];
        pending_ops.push_back(o);
        if (f == FN_PUSH && plan_depth[o.dst] < STACK_DEPTH) begin
            plan_depth[o.dst]++;
        end else if (f == FN_MOVE && o.src != o.dst && o.cnt <= plan_depth[o.src] &&
                     plan_depth[o.dst] + o.cnt <= STACK_DEPTH) begin
            plan_depth[o.src] -= o.cnt;
            plan_depth[o.dst] += o.cnt;
        end
    endtask

    task automatic plan_random_ops();
        int r, s, d, ds, room, c, sub;
        logic [31:0] w;
        while (pending_ops.size() < N_RANDOM + 25) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, NUM_STACKS - 1);
            d = $urandom_range(0, NUM_STACKS - 1);
            if (r < 1) begin
                // fill one stack to the brim, then try once more
                while (plan_depth[d] < STACK_DEPTH)
                    queue_op(FN_PUSH, 0, d, $urandom_range(0, 255), $urandom_range(0, 255));
                queue_op(FN_PUSH, s, d, $urandom_range(0, 255), $urandom_range(0, 255));
                queue_op(FN_PEEK, d, s, 0, 0);
            end else if (r < 40) begin
                queue_op(FN_PUSH, s, d, $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (r < 75) begin
                if (s == d && $urandom_range(0, 7) != 0)
                    d = (d + $urandom_range(1, NUM_STACKS - 1)) % NUM_STACKS;
                ds   = plan_depth[s];
                room = STACK_DEPTH - plan_depth[d];
                sub  = $urandom_range(0, 9);
                case (sub)
                    6:       c = ds;
                    7:       c = $urandom_range(0, 255);
                    8:       c = ds + 1;
                    9:       c = (ds > room) ? ds : room + 1;
                    default: c = $urandom_range(0, (ds < 12) ? ds : 12);
                endcase
                if (c > 255)
                    c = 255;
                queue_op(FN_MOVE, s, d, c, $urandom_range(0, 255));
            end else if (r < 92) begin
                queue_op(FN_PEEK, s, d, $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                w = $urandom;
                queue_op(w[1:0], w[5:2], w[9:6], w[17:10], w[25:18]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transactions separated by random gaps
    // ------------------------------------------------------------------
    stack_op_t cur_op;
    int        gap_left   = 0;
    int        burst_left = 1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_stack_op(cur_op));
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    cur_op = pending_ops.pop_front();
                    s_tdata  <= {6'd0, cur_op};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: ready follows a rotating pattern, reloaded now and then
    // ------------------------------------------------------------------
    logic [7:0] ready_pat  = 8'hFF;
    int         pat_cycles = 0;
    stack_res_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[17:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.top !== want.top) begin
                        $display("%0t: top_value expected %0d actual %0d",
                                 $time, want.top, got.top);
                        n_errors++;
                    end
                    if (got.depth !== want.depth) begin
                        $display("%0t: stack_depth expected %0d actual %0d",
                                 $time, want.depth, got.depth);
                        n_errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        n_errors++;
                    end
                end
            end
            pat_cycles++;
            if (pat_cycles >= 97) begin
                pat_cycles = 0;
                // keep one ready bit so a stall never lasts a full rotation
                ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end
            m_tready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[7:1]};
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[multi_stack_block_move] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed opening, random body, drain
    // ------------------------------------------------------------------
    initial begin
        for (int k = 0; k < NUM_STACKS; k++) begin
            plan_depth[k] = 0;
            depth_tbl[k]  = 0;
        end

        queue_op(FN_PEEK, 0, 0, 0, 0);          // empty stack
        queue_op(FN_PUSH, 0, 0, 0, 8'h00);
        queue_op(FN_PUSH, 15, 15, 255, 8'hFF);
        queue_op(FN_PUSH, 3, 0, 128, 8'hAA);
        queue_op(FN_PUSH, 0, 0, 0, 8'h55);
        queue_op(FN_PEEK, 0, 15, 0, 0);
        queue_op(FN_PEEK, 15, 0, 0, 0);
        queue_op(FN_MOVE, 0, 1, 0, 0);          // zero items
        queue_op(FN_MOVE, 3, 3, 1, 0);          // same stack
        queue_op(FN_MOVE, 1, 2, 5, 0);          // source empty
        queue_op(FN_MOVE, 0, 2, 255, 8'hFF);    // far more than held
        queue_op(FN_MOVE, 0, 15, 2, 0);         // block keeps order
        queue_op(FN_PEEK, 0, 0, 0, 0);
        queue_op(FN_PEEK, 15, 0, 0, 0);
        queue_op(FN_MOVE, 15, 0, 3, 0);
        queue_op(FN_MOVE, 0, 15, 128, 0);       // underflow with count 128
        queue_op(2'd3, 15, 15, 255, 255);       // unused operation
        queue_op(2'd3, 0, 0, 0, 0);
        queue_op(FN_PEEK, 0, 0, 0, 0);
        queue_op(FN_MOVE, 0, 7, 3, 0);          // into an empty stack
        queue_op(FN_PEEK, 7, 7, 0, 0);
        plan_random_ops();
        n_total = pending_ops.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_total || expected_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (n_errors == 0) begin
            $display("[multi_stack_block_move] OK");
        end else begin
            $display("[multi_stack_block_move] ERROR");
        end
        $finish;
    end

endmodule
